// ===== rtl/core/xlds_pkg.sv =====
package xlds_pkg;

  localparam int MaxInsnLen = 16;
  localparam int CfgAddrW   = 2;

  localparam logic [CfgAddrW-1:0] AddrMinSpan = 2'd0;
  localparam logic [4:0]          MinSpanRst  = 5'd5;

  localparam logic [7:0] OpPfxOpsize = 8'h66;
  localparam logic [7:0] OpPfxAdsize = 8'h67;
  localparam logic [7:0] OpPfxRepne  = 8'hF2;
  localparam logic [7:0] OpPfxRep    = 8'hF3;
  localparam logic [7:0] OpEscape    = 8'h0F;
  localparam logic [7:0] OpEscMovups = 8'h10;
  localparam logic [7:0] OpEscMovupsSt = 8'h11;
  localparam logic [7:0] OpPushReg   = 8'h50;
  localparam logic [7:0] OpNop       = 8'h90;
  localparam logic [7:0] OpMovRegImm = 8'hB8;
  localparam logic [7:0] OpPushImm8  = 8'h6A;
  localparam logic [7:0] OpPushImm32 = 8'h68;
  localparam logic [7:0] OpMovMoffsLd = 8'hA1;
  localparam logic [7:0] OpMovMoffsSt = 8'hA3;
  localparam logic [7:0] OpGrp1Imm8  = 8'h83;
  localparam logic [7:0] OpGrp1Imm32 = 8'h81;
  localparam logic [7:0] OpMovRmImm  = 8'hC7;

  localparam logic [1:0] ModReg  = 2'd3;
  localparam logic [1:0] ModDisp8 = 2'd1;
  localparam logic [1:0] ModDisp32 = 2'd2;
  localparam logic [1:0] ModNoDisp = 2'd0;
  localparam logic [2:0] RmSib    = 3'd4;
  localparam logic [2:0] RmDisp32 = 3'd5;

  typedef enum logic [4:0] {
    PhLead  = 5'b00001,
    PhEsc   = 5'b00010,
    PhModrm = 5'b00100,
    PhSib   = 5'b01000,
    PhTail  = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    StAccept   = 2'd0,
    StComplete = 2'd1,
    StReject   = 2'd2
  } status_t;

  typedef struct packed {
    phase_t     phase;
    logic [4:0] seen;
    logic [3:0] rem;
    logic [7:0] modrm;
    logic [2:0] imm;
    logic [5:0] span;
    logic       done;
  } scan_state_t;

  typedef struct packed {
    logic [4:0] insn_length;
    logic [5:0] span_total;
    status_t    status;
  } result_t;

endpackage

// ===== rtl/core/xlds_in_if.sv =====
interface xlds_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       restart;

  modport source (output valid, output code_byte, output restart, input ready);
  modport sink (input valid, input code_byte, input restart, output ready);
endinterface

// ===== rtl/core/xlds_out_if.sv =====
interface xlds_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] insn_length;
  logic [5:0] span_total;
  logic [1:0] status;

  modport source (output valid, output insn_length, output span_total, output status,
                  input ready);
  modport sink (input valid, input insn_length, input span_total, input status,
                output ready);
endinterface

// ===== rtl/core/xlds_cfg.sv =====
module xlds_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [xlds_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [4:0]                    min_span
);

  logic [4:0] min_span_r;
  logic [4:0] min_span_nxt;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == xlds_pkg::AddrMinSpan);

  always_comb begin
    min_span_nxt = min_span_r;
    if (wr_en) begin
      min_span_nxt = pwdata[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_span_r <= xlds_pkg::MinSpanRst;
    end else begin
      min_span_r <= min_span_nxt;
    end
  end

  assign prdata   = (paddr == xlds_pkg::AddrMinSpan) ? {27'd0, min_span_r} : 32'd0;
  assign min_span = min_span_r;

endmodule

// ===== rtl/core/xlds_decode.sv =====
module xlds_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        code_byte,
  input  logic              restart,
  input  logic [4:0]        min_span,
  output logic              res_valid,
  output xlds_pkg::result_t res
);

  xlds_pkg::scan_state_t state_r;
  xlds_pkg::scan_state_t state_nxt;
  xlds_pkg::scan_state_t st_cur;
  logic [4:0] seen_inc;
  logic [3:0] rem_dec;
  logic [3:0] disp;
  logic [3:0] rest;
  logic [5:0] span_sum;
  logic [1:0] md;
  logic [2:0] low;
  logic [1:0] held_md;
  logic       do_finish;
  logic       do_reject;
  logic       do_operand;

  function automatic logic has_modrm_plain(input logic [7:0] b);
    logic hit;
    unique case (b)
      8'h01, 8'h03, 8'h29, 8'h2B, 8'h31, 8'h33, 8'h39, 8'h3B,
      8'h84, 8'h85, 8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8D, 8'hFF: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  assign md      = code_byte[7:6];
  assign low     = code_byte[2:0];
  assign held_md = state_r.modrm[7:6];

  always_comb begin
    st_cur = state_r;
    if (restart) begin
      st_cur.phase = xlds_pkg::PhLead;
      st_cur.seen  = 5'd0;
      st_cur.rem   = 4'd0;
      st_cur.modrm = 8'd0;
      st_cur.imm   = 3'd0;
      st_cur.span  = 6'd0;
      st_cur.done  = 1'b0;
    end
    seen_inc   = st_cur.seen + 5'd1;
    rem_dec    = (st_cur.rem != 4'd0) ? st_cur.rem - 4'd1 : 4'd0;
    state_nxt  = state_r;
    do_finish  = 1'b0;
    do_reject  = 1'b0;
    do_operand = 1'b0;
    disp       = 4'd0;
    res_valid  = 1'b0;
    res.insn_length = 5'd0;
    res.span_total  = st_cur.span;
    res.status      = xlds_pkg::StAccept;

    if (step && !st_cur.done) begin
      state_nxt      = st_cur;
      state_nxt.seen = seen_inc;
      if (seen_inc > 5'(xlds_pkg::MaxInsnLen)) begin
        do_reject = 1'b1;
      end else begin
        unique case (st_cur.phase)
          xlds_pkg::PhEsc: begin
            if (code_byte == xlds_pkg::OpEscMovups || code_byte == xlds_pkg::OpEscMovupsSt) begin
              state_nxt.imm   = 3'd0;
              state_nxt.phase = xlds_pkg::PhModrm;
            end else begin
              do_reject = 1'b1;
            end
          end
          xlds_pkg::PhModrm: begin
            state_nxt.modrm = code_byte;
            if (md != xlds_pkg::ModReg && low == xlds_pkg::RmSib) begin
              state_nxt.phase = xlds_pkg::PhSib;
            end else begin
              do_operand = 1'b1;
              priority if (md == xlds_pkg::ModNoDisp) begin
                disp = (low == xlds_pkg::RmDisp32) ? 4'd4 : 4'd0;
              end else if (md == xlds_pkg::ModDisp8) begin
                disp = 4'd1;
              end else if (md == xlds_pkg::ModDisp32) begin
                disp = 4'd4;
              end else begin
                disp = 4'd0;
              end
            end
          end
          xlds_pkg::PhSib: begin
            do_operand = 1'b1;
            priority if (held_md == xlds_pkg::ModNoDisp) begin
              disp = (low == xlds_pkg::RmDisp32) ? 4'd4 : 4'd0;
            end else if (held_md == xlds_pkg::ModDisp8) begin
              disp = 4'd1;
            end else begin
              disp = 4'd4;
            end
          end
          xlds_pkg::PhTail: begin
            state_nxt.rem = rem_dec;
            if (rem_dec == 4'd0) begin
              do_finish = 1'b1;
            end
          end
          default: begin
            state_nxt.phase = xlds_pkg::PhLead;
            priority if (code_byte == xlds_pkg::OpPfxOpsize || code_byte == xlds_pkg::OpPfxAdsize ||
                         code_byte == xlds_pkg::OpPfxRepne || code_byte == xlds_pkg::OpPfxRep) begin
              state_nxt.phase = xlds_pkg::PhLead;
            end else if (code_byte == xlds_pkg::OpEscape) begin
              state_nxt.phase = xlds_pkg::PhEsc;
            end else if (code_byte[7:4] == xlds_pkg::OpPushReg[7:4] ||
                         code_byte == xlds_pkg::OpNop) begin
              do_finish = 1'b1;
            end else if (code_byte == xlds_pkg::OpPushImm8) begin
              state_nxt.rem   = 4'd1;
              state_nxt.phase = xlds_pkg::PhTail;
            end else if (code_byte == xlds_pkg::OpPushImm32 ||
                         code_byte[7:3] == xlds_pkg::OpMovRegImm[7:3] ||
                         code_byte == xlds_pkg::OpMovMoffsLd ||
                         code_byte == xlds_pkg::OpMovMoffsSt) begin
              state_nxt.rem   = 4'd4;
              state_nxt.phase = xlds_pkg::PhTail;
            end else if (has_modrm_plain(code_byte)) begin
              state_nxt.imm   = 3'd0;
              state_nxt.phase = xlds_pkg::PhModrm;
            end else if (code_byte == xlds_pkg::OpGrp1Imm8) begin
              state_nxt.imm   = 3'd1;
              state_nxt.phase = xlds_pkg::PhModrm;
            end else if (code_byte == xlds_pkg::OpGrp1Imm32 ||
                         code_byte == xlds_pkg::OpMovRmImm) begin
              state_nxt.imm   = 3'd4;
              state_nxt.phase = xlds_pkg::PhModrm;
            end else begin
              do_reject = 1'b1;
            end
          end
        endcase
      end
    end

    rest     = disp + {1'b0, st_cur.imm};
    span_sum = st_cur.span + {1'b0, seen_inc};

    if (do_operand) begin
      if (rest == 4'd0) begin
        do_finish = 1'b1;
      end else begin
        state_nxt.rem   = rest;
        state_nxt.phase = xlds_pkg::PhTail;
      end
    end

    if (do_finish || do_reject) begin
      res_valid       = 1'b1;
      state_nxt.phase = xlds_pkg::PhLead;
      state_nxt.seen  = 5'd0;
      state_nxt.rem   = 4'd0;
      state_nxt.modrm = 8'd0;
      state_nxt.imm   = 3'd0;
    end

    if (do_finish) begin
      state_nxt.span  = span_sum;
      res.insn_length = seen_inc;
      res.span_total  = span_sum;
      if (span_sum >= {1'b0, min_span}) begin
        res.status     = xlds_pkg::StComplete;
        state_nxt.done = 1'b1;
      end
    end

    if (do_reject) begin
      res.insn_length = 5'd0;
      res.span_total  = st_cur.span;
      res.status      = xlds_pkg::StReject;
      state_nxt.done  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase <= xlds_pkg::PhLead;
      state_r.seen  <= 5'd0;
      state_r.rem   <= 4'd0;
      state_r.modrm <= 8'd0;
      state_r.imm   <= 3'd0;
      state_r.span  <= 6'd0;
      state_r.done  <= 1'b0;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/x86_length_decode_span_top.sv =====
// Order: an accepted byte waits in the input register while the decode stage loads
//   the result register; a stall on out_ch.ready holds both registers.
// Throughput: one byte per cycle when unstalled; one decode stage and result reg set it.
// Reset: synchronous, active-low rst_n empties both registers, clears the scan state
//   and sets min_span to 5.
module x86_length_decode_span_top (
  input  logic                          clk,
  input  logic                          rst_n,
  xlds_in_if.sink                       in_ch,
  xlds_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [xlds_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  logic              in_valid_r;
  logic              in_valid_nxt;
  logic [7:0]        in_byte_r;
  logic              in_restart_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  xlds_pkg::result_t out_res_r;
  xlds_pkg::result_t dec_res;
  logic              dec_valid;
  logic              step;
  logic              in_take;
  logic [4:0]        min_span;

  xlds_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready),
    .min_span (min_span)
  );

  xlds_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .code_byte (in_byte_r),
    .restart   (in_restart_r),
    .min_span  (min_span),
    .res_valid (dec_valid),
    .res       (dec_res)
  );

  assign step        = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || step;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step && dec_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r    <= in_ch.code_byte;
      in_restart_r <= in_ch.restart;
    end
    if (step && dec_valid) begin
      out_res_r <= dec_res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.insn_length = out_res_r.insn_length;
  assign out_ch.span_total  = out_res_r.span_total;
  assign out_ch.status      = out_res_r.status;

  a_reject_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == xlds_pkg::StReject |-> out_ch.insn_length == 5'd0)
    else $error("rejected item carries a nonzero length");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.insn_length <= 5'(xlds_pkg::MaxInsnLen))
    else $error("instruction length above limit");

  a_cfg_reset: assert property (@(posedge clk) !rst_n |=> min_span == xlds_pkg::MinSpanRst)
    else $error("min_span not at reset value");

  a_step_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> in_valid_r && (!out_valid_r || out_ch.ready))
    else $error("decode stepped with no item or no room");

endmodule
